@@ rtl/lrbf_pkg.sv @@
`default_nettype none

package lrbf_pkg;

   localparam int unsigned LRBF_BLOCK_SIZE = 32768;

   localparam int unsigned OFFSET_W = 15;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned PAD_W    = 3;
   localparam int unsigned TYPE_W   = 3;
   localparam int unsigned CRC_W    = 32;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned HDR_SIZE = 7;
   localparam int unsigned RES_SLOTS = 3;
   localparam int unsigned CNT_W    = 2;

   localparam logic [KIND_W-1:0] KIND_PAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HDR  = 2'd2;

   localparam logic [TYPE_W-1:0] FT_FULL   = 3'd1;
   localparam logic [TYPE_W-1:0] FT_FIRST  = 3'd2;
   localparam logic [TYPE_W-1:0] FT_MIDDLE = 3'd3;
   localparam logic [TYPE_W-1:0] FT_LAST   = 3'd4;

   localparam logic [CRC_W-1:0] CRC_SEED = 32'hffff_ffff;
   localparam logic [CRC_W-1:0] CRC_POLY = 32'h82f6_3b78;
   localparam logic [CRC_W-1:0] CRC_MASK_ADD = 32'ha282_ead8;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [BYTE_W-1:0]   data;
      logic [PAD_W-1:0]    pad;
      logic [OFFSET_W-1:0] pos;
      logic [OFFSET_W-1:0] len;
      logic [TYPE_W-1:0]   ftype;
      logic [CRC_W-1:0]    crc;
   } result_type;

   function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] r_in,
                                                    input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] r;
      r = r_in ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [CRC_W-1:0] crc_mask(input logic [CRC_W-1:0] r);
      logic [CRC_W-1:0] c;
      c = ~r;
      return {c[14:0], c[31:15]} + CRC_MASK_ADD;
   endfunction

   localparam logic [CRC_W-1:0] CRC_INIT_FULL   = crc32c_byte(CRC_SEED, 8'(FT_FULL));
   localparam logic [CRC_W-1:0] CRC_INIT_FIRST  = crc32c_byte(CRC_SEED, 8'(FT_FIRST));
   localparam logic [CRC_W-1:0] CRC_INIT_MIDDLE = crc32c_byte(CRC_SEED, 8'(FT_MIDDLE));
   localparam logic [CRC_W-1:0] CRC_INIT_LAST   = crc32c_byte(CRC_SEED, 8'(FT_LAST));

endpackage

`default_nettype wire

@@ rtl/lrbf_cfg_mod.sv @@
`default_nettype none

module lrbf_cfg_mod
   import lrbf_pkg::*;
#(
   parameter int unsigned BLOCK_SIZE = LRBF_BLOCK_SIZE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [OFFSET_W-1:0]           wr_data,
   output logic                               busy,
   output logic                               load_valid,
   output logic [$clog2(BLOCK_SIZE)-1:0]      load_value
);

   localparam int unsigned AW = $clog2(BLOCK_SIZE);
   localparam int unsigned RW = $clog2(2 * BLOCK_SIZE);
   localparam longint unsigned RECIP = (longint'(1) << 32) / BLOCK_SIZE;
   localparam int unsigned RECIP_W = $clog2(RECIP + 1);
   localparam int unsigned PROD_W = OFFSET_W + RECIP_W;

   logic                s1_valid_ff;
   logic [OFFSET_W-1:0] s1_x_ff;
   logic [PROD_W-1:0]   s1_prod_ff;
   logic [PROD_W-1:0]   s1_prod_in;
   logic                s2_valid_ff;
   logic [RW-1:0]       s2_rem_ff;
   logic [RW-1:0]       s2_rem_in;
   logic [OFFSET_W-1:0] quot;
   logic [31:0]         rem_wide;
   logic [RW-1:0]       rem_fix;

   // quotient estimate by reciprocal, at most one low
   assign s1_prod_in = PROD_W'(wr_data) * PROD_W'(RECIP);
   assign quot       = OFFSET_W'(s1_prod_ff >> 32);
   assign rem_wide   = 32'(s1_x_ff) - (32'(quot) * 32'(BLOCK_SIZE));
   assign s2_rem_in  = RW'(rem_wide);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= wr_en;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_x_ff    <= wr_data;
      s1_prod_ff <= s1_prod_in;
      s2_rem_ff  <= s2_rem_in;
   end

   always_comb begin
      rem_fix = s2_rem_ff;
      if (s2_rem_ff >= RW'(BLOCK_SIZE)) begin
         rem_fix = s2_rem_ff - RW'(BLOCK_SIZE);
      end
   end

   assign load_value = AW'(rem_fix);
   assign load_valid = s2_valid_ff;
   assign busy       = wr_en | s1_valid_ff | s2_valid_ff;

endmodule

`default_nettype wire

@@ rtl/lrbf_framer.sv @@
`default_nettype none

module lrbf_framer
   import lrbf_pkg::*;
#(
   parameter int unsigned BLOCK_SIZE = LRBF_BLOCK_SIZE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic [BYTE_W-1:0]             data_byte,
   input  wire logic                          last_of_record,
   input  wire logic                          empty_record,
   input  wire logic                          load_valid,
   input  wire logic [$clog2(BLOCK_SIZE)-1:0] load_value,
   output result_type                         res_out [RES_SLOTS],
   output logic [CNT_W-1:0]                   res_count
);

   localparam int unsigned PW = $clog2(BLOCK_SIZE + 1);
   localparam int unsigned AW = $clog2(BLOCK_SIZE);
   localparam logic [PW-1:0] BLK = PW'(BLOCK_SIZE);
   localparam logic [PW-1:0] HDR = PW'(HDR_SIZE);

   logic [PW-1:0]    bp_ff, bp_in;
   logic [AW-1:0]    hp_ff, hp_in;
   logic [AW-1:0]    fb_ff, fb_in;
   logic             open_ff, open_in;
   logic             first_ff, first_in;
   logic [CRC_W-1:0] ce_ff, ce_in;
   logic [CRC_W-1:0] cc_ff, cc_in;
   logic [PW-1:0]    left;
   logic [CNT_W-1:0] n;
   result_type       res [RES_SLOTS];

   always_comb begin
      bp_in    = bp_ff;
      hp_in    = hp_ff;
      fb_in    = fb_ff;
      open_in  = open_ff;
      first_in = first_ff;
      ce_in    = ce_ff;
      cc_in    = cc_ff;
      left     = '0;
      n        = '0;
      for (int i = 0; i < RES_SLOTS; i++) begin
         res[i] = '0;
      end

      if (!open_in) begin
         left = BLK - bp_in;
         if (left < HDR) begin
            if (left != '0) begin
               res[n].kind = KIND_PAD;
               res[n].pad  = PAD_W'(left);
               res[n].pos  = OFFSET_W'(bp_in);
               n = n + 2'd1;
            end
            bp_in = '0;
         end
         hp_in   = AW'(bp_in);
         bp_in   = bp_in + HDR;
         fb_in   = '0;
         ce_in   = first_in ? CRC_INIT_FULL : CRC_INIT_LAST;
         cc_in   = first_in ? CRC_INIT_FIRST : CRC_INIT_MIDDLE;
         open_in = 1'b1;
         // header landed on a 7-byte tail: close it empty, reopen in next block
         if (!empty_record && (bp_in >= BLK)) begin
            res[n].kind  = KIND_HDR;
            res[n].pos   = OFFSET_W'(hp_in);
            res[n].len   = OFFSET_W'(fb_in);
            res[n].ftype = first_in ? FT_FIRST : FT_MIDDLE;
            res[n].crc   = crc_mask(cc_in);
            n = n + 2'd1;
            first_in = 1'b0;
            hp_in    = '0;
            bp_in    = HDR;
            fb_in    = '0;
            ce_in    = CRC_INIT_LAST;
            cc_in    = CRC_INIT_MIDDLE;
         end
      end

      if (empty_record) begin
         res[n].kind  = KIND_HDR;
         res[n].pos   = OFFSET_W'(hp_in);
         res[n].len   = OFFSET_W'(fb_in);
         res[n].ftype = first_in ? FT_FULL : FT_LAST;
         res[n].crc   = crc_mask(ce_in);
         n = n + 2'd1;
         open_in  = 1'b0;
         first_in = 1'b1;
      end else begin
         res[n].kind = KIND_BYTE;
         res[n].data = data_byte;
         res[n].pos  = OFFSET_W'(bp_in);
         n = n + 2'd1;
         ce_in = crc32c_byte(ce_in, data_byte);
         cc_in = crc32c_byte(cc_in, data_byte);
         bp_in = bp_in + PW'(1);
         fb_in = fb_in + AW'(1);
         if (last_of_record || (bp_in >= BLK)) begin
            res[n].kind  = KIND_HDR;
            res[n].pos   = OFFSET_W'(hp_in);
            res[n].len   = OFFSET_W'(fb_in);
            if (last_of_record) begin
               res[n].ftype = first_in ? FT_FULL : FT_LAST;
               res[n].crc   = crc_mask(ce_in);
            end else begin
               res[n].ftype = first_in ? FT_FIRST : FT_MIDDLE;
               res[n].crc   = crc_mask(cc_in);
            end
            n = n + 2'd1;
            open_in  = 1'b0;
            first_in = last_of_record;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff    <= '0;
         hp_ff    <= '0;
         fb_ff    <= '0;
         open_ff  <= 1'b0;
         first_ff <= 1'b1;
         ce_ff    <= '0;
         cc_ff    <= '0;
      end else if (take) begin
         bp_ff    <= bp_in;
         hp_ff    <= hp_in;
         fb_ff    <= fb_in;
         open_ff  <= open_in;
         first_ff <= first_in;
         ce_ff    <= ce_in;
         cc_ff    <= cc_in;
      end else if (load_valid && !open_ff && first_ff) begin
         bp_ff <= PW'(load_value);
      end
   end

   assign res_out   = res;
   assign res_count = n;

endmodule

`default_nettype wire

@@ rtl/lrbf_rsp_buf.sv @@
`default_nettype none

module lrbf_rsp_buf
   import lrbf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire result_type       res_in [RES_SLOTS],
   input  wire logic [CNT_W-1:0] count_in,
   input  wire logic             rsp_ready,
   output logic                  free,
   output logic                  rsp_valid,
   output result_type            rsp_res,
   output logic                  rsp_last
);

   result_type       res_ff [RES_SLOTS];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             final_beat;
   logic             drain;

   assign rsp_valid  = (cnt_ff != '0);
   assign final_beat = (idx_ff == (cnt_ff - 2'd1));
   assign drain      = rsp_valid & rsp_ready;
   assign free       = !rsp_valid || (rsp_ready && final_beat);
   assign rsp_res    = res_ff[idx_ff];
   assign rsp_last   = final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (take) begin
         cnt_ff <= count_in;
         idx_ff <= '0;
      end else if (drain) begin
         if (final_beat) begin
            cnt_ff <= '0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/log_record_block_framer_core.sv @@
// Log record block framer.
// req_* channel: one payload byte per beat with an end-of-record flag, or an
// empty-record beat standing for a zero-length record.
// rsp_* channel: one beat per pad run, payload byte or fragment header, in
// stream order; up to three beats per request beat, rsp_last_result on the
// last of them. Headers carry length, type and the masked CRC32C.
// csr_wr_en/csr_wr_data load the starting in-block offset (file length);
// the offset is reduced modulo the block size in a pipelined unit, during
// which req_ready is low.
// A request beat's responses are registered in the response buffer, and
// its first response beat shows in the cycle after the beat is accepted.
// Request beats are taken one per cycle while each yields one response
// and rsp_ready is high; a beat yielding more than one response holds the
// single response slot set until all of them drain. A new request beat is
// taken in the same cycle the last response of the previous one is taken.
// Reset: synchronous, active high; offset 0, no fragment open, next
// fragment is the first of a record. When rsp_ready stays low, the pending
// response holds and req_ready drops until it drains.
`default_nettype none

module log_record_block_framer_core
   import lrbf_pkg::*;
#(
   parameter int unsigned BLOCK_SIZE = LRBF_BLOCK_SIZE
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [BYTE_W-1:0]   req_data_byte,
   input  wire logic                req_last_of_record,
   input  wire logic                req_empty_record,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [KIND_W-1:0]        rsp_item_kind,
   output logic [BYTE_W-1:0]        rsp_payload_byte,
   output logic [PAD_W-1:0]         rsp_pad_count,
   output logic [OFFSET_W-1:0]      rsp_position,
   output logic [OFFSET_W-1:0]      rsp_frag_length,
   output logic [TYPE_W-1:0]        rsp_frag_type,
   output logic [CRC_W-1:0]         rsp_masked_crc,
   output logic                     rsp_last_result,
   input  wire logic                csr_wr_en,
   input  wire logic [OFFSET_W-1:0] csr_wr_data
);

   localparam int unsigned AW = $clog2(BLOCK_SIZE);

   logic             cfg_busy;
   logic             load_valid;
   logic [AW-1:0]    load_value;
   logic             buf_free;
   logic             take;
   result_type       res [RES_SLOTS];
   logic [CNT_W-1:0] res_count;
   result_type       rsp_res;

   assign req_ready = buf_free & ~cfg_busy;
   assign take      = req_valid & req_ready;

   lrbf_cfg_mod #(
      .BLOCK_SIZE(BLOCK_SIZE)
   ) u_cfg_mod (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (csr_wr_en),
      .wr_data    (csr_wr_data),
      .busy       (cfg_busy),
      .load_valid (load_valid),
      .load_value (load_value)
   );

   lrbf_framer #(
      .BLOCK_SIZE(BLOCK_SIZE)
   ) u_framer (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .data_byte      (req_data_byte),
      .last_of_record (req_last_of_record),
      .empty_record   (req_empty_record),
      .load_valid     (load_valid),
      .load_value     (load_value),
      .res_out        (res),
      .res_count      (res_count)
   );

   lrbf_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .res_in    (res),
      .count_in  (res_count),
      .rsp_ready (rsp_ready),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res),
      .rsp_last  (rsp_last_result)
   );

   assign rsp_item_kind    = rsp_res.kind;
   assign rsp_payload_byte = rsp_res.data;
   assign rsp_pad_count    = rsp_res.pad;
   assign rsp_position     = rsp_res.pos;
   assign rsp_frag_length  = rsp_res.len;
   assign rsp_frag_type    = rsp_res.ftype;
   assign rsp_masked_crc   = rsp_res.crc;

endmodule

`default_nettype wire
